>>> rtl/core/pcmfc_pkg.sv
// ============================================================================
// pcmfc_pkg: shared types and helpers for the PCM sample format converter
// Holds the source format codes, the channel payload types and the
// leading-zero count used by the integer-to-binary32 path.
// ============================================================================
package pcmfc_pkg;

   // Source format codes, as written to the format register
   typedef enum logic [3:0] {
      FMT_U8    = 4'd0,
      FMT_S8    = 4'd1,
      FMT_S16LE = 4'd2,
      FMT_S16BE = 4'd3,
      FMT_S24LE = 4'd4,
      FMT_S24BE = 4'd5,
      FMT_S32LE = 4'd6,
      FMT_S32BE = 4'd7,
      FMT_F32   = 4'd8,
      FMT_F64   = 4'd9
   } fmt_type;

   localparam int unsigned FMT_W = 4;

   // Exponent for a 32-bit value with its leading one at bit 31, before
   // the leading-zero count is taken off (2^-31 and 2^-23 scale folded in)
   localparam logic [7:0] EXP_TOP_S32 = 8'd127;
   localparam logic [7:0] EXP_TOP_S24 = 8'd135;

   // f64 exponent range limits
   localparam logic [10:0] F64_EXP_MAX   = 11'h7FF;
   localparam logic [10:0] F64_EXP_OVF   = 11'd1151;  // at and above: infinity
   localparam logic [10:0] F64_EXP_NORM  = 11'd897;   // at and above: normal
   localparam logic [10:0] F64_EXP_SUBLO = 11'd872;   // below: signed zero
   localparam logic [10:0] F64_SUB_SHIFT = 11'd926;

   localparam logic [30:0] F32_INF_MAG = 31'h7F800000;
   localparam logic [30:0] F32_QNAN    = 31'h7FC00000;

   typedef struct packed {
      logic [63:0] raw_bytes;
      logic        final_item;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_word;
      logic        is_float;
      logic        final_out;
   } rsp_type;

   typedef logic [FMT_W-1:0] csr_type;

   // Count of leading zeros of a 32-bit word (32 when zero)
   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/core/pcmfc_chan_if.sv
// ============================================================================
// pcmfc_chan_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ============================================================================
interface pcmfc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/pcmfc_convert.sv
// ============================================================================
// pcmfc_convert: sample conversion datapath
// Byte ordering for 8/16-bit formats, integer to binary32 with RNE for
// 24/32-bit formats, f32 pass-through and f64 to f32 rounding.
// ============================================================================
module pcmfc_convert (
   input  pcmfc_pkg::fmt_type fmt,
   input  logic [63:0]        raw,
   output logic [31:0]        word,
   output logic               is_float
);

   logic [7:0]  b0, b1, b2, b3;
   logic [31:0] int_val;
   logic        int_is24;
   logic        int_sign;
   logic [31:0] int_mag;
   logic [5:0]  int_lz;
   logic [31:0] int_norm;
   logic [7:0]  int_exp;
   logic        int_up;
   logic [31:0] int_f;

   logic [10:0]  dex;
   logic [51:0]  dman;
   logic         dsign;
   logic [30:0]  dbase;
   logic [28:0]  drem;
   logic         dup;
   logic [5:0]   dsh;
   logic [116:0] dext;
   logic [23:0]  dq;
   logic         dsub_up;
   logic [30:0]  dmag;
   logic [31:0]  dbl_f;

   assign b0 = raw[7:0];
   assign b1 = raw[15:8];
   assign b2 = raw[23:16];
   assign b3 = raw[31:24];

   // Pick the integer sample and sign-extend 24-bit values
   always_comb begin
      int_is24 = 1'b1;
      int_val  = {{8{b2[7]}}, b2, b1, b0};
      unique case (fmt)
         pcmfc_pkg::FMT_S24BE: int_val = {{8{b0[7]}}, b0, b1, b2};
         pcmfc_pkg::FMT_S32LE: begin
            int_val  = {b3, b2, b1, b0};
            int_is24 = 1'b0;
         end
         pcmfc_pkg::FMT_S32BE: begin
            int_val  = {b0, b1, b2, b3};
            int_is24 = 1'b0;
         end
         default: ;
      endcase
   end

   // Integer to binary32: normalize, round to nearest even
   always_comb begin
      int_sign = int_val[31];
      int_mag  = int_sign ? (~int_val + 32'd1) : int_val;
      int_lz   = pcmfc_pkg::lzc32(int_mag);
      int_norm = int_mag << int_lz;
      int_exp  = (int_is24 ? pcmfc_pkg::EXP_TOP_S24 : pcmfc_pkg::EXP_TOP_S32)
                 - {2'b00, int_lz};
      int_up   = int_norm[7] && ((|int_norm[6:0]) || int_norm[8]);
      if (int_mag == 32'd0) begin
         int_f = 32'd0;
      end else begin
         int_f = {int_sign, int_exp, int_norm[30:8]} + {31'd0, int_up};
      end
   end

   // f64 to f32
   always_comb begin
      dsign   = raw[63];
      dex     = raw[62:52];
      dman    = raw[51:0];
      dbase   = {dex[7:0] - 8'd128, dman[51:29]};
      drem    = dman[28:0];
      dup     = drem[28] && ((|drem[27:0]) || dbase[0]);
      dsh     = 6'(pcmfc_pkg::F64_SUB_SHIFT - dex);
      dext    = {1'b1, dman, 64'd0} >> dsh;
      dq      = dext[87:64];
      dsub_up = dext[63] && ((|dext[62:0]) || dq[0]);
      priority if (dex == pcmfc_pkg::F64_EXP_MAX) begin
         dmag = (dman == 52'd0) ? pcmfc_pkg::F32_INF_MAG
                : (pcmfc_pkg::F32_QNAN | {8'd0, dman[51:29]});
      end else if (dex == 11'd0) begin
         dmag = 31'd0;
      end else if (dex >= pcmfc_pkg::F64_EXP_OVF) begin
         dmag = pcmfc_pkg::F32_INF_MAG;
      end else if (dex >= pcmfc_pkg::F64_EXP_NORM) begin
         dmag = dbase + {30'd0, dup};
      end else if (dex < pcmfc_pkg::F64_EXP_SUBLO) begin
         dmag = 31'd0;
      end else begin
         dmag = {7'd0, dq + {23'd0, dsub_up}};
      end
      dbl_f = {dsign, dmag};
   end

   // Result select by format
   always_comb begin
      word     = 32'd0;
      is_float = 1'b1;
      unique case (fmt)
         pcmfc_pkg::FMT_U8: begin
            word     = {16'd0, b0 ^ 8'h80, 8'd0};
            is_float = 1'b0;
         end
         pcmfc_pkg::FMT_S8: begin
            word     = {16'd0, b0, 8'd0};
            is_float = 1'b0;
         end
         pcmfc_pkg::FMT_S16LE: begin
            word     = {16'd0, b1, b0};
            is_float = 1'b0;
         end
         pcmfc_pkg::FMT_S16BE: begin
            word     = {16'd0, b0, b1};
            is_float = 1'b0;
         end
         pcmfc_pkg::FMT_S24LE, pcmfc_pkg::FMT_S24BE,
         pcmfc_pkg::FMT_S32LE, pcmfc_pkg::FMT_S32BE: word = int_f;
         pcmfc_pkg::FMT_F32: word = raw[31:0];
         pcmfc_pkg::FMT_F64: word = dbl_f;
         default: is_float = 1'b0;
      endcase
   end

endmodule

>>> rtl/core/pcm_sample_format_converter.sv
// ============================================================================
// pcm_sample_format_converter: raw PCM sample to int16 or binary32
// Two-register pipeline: input register, conversion, result register.
// ============================================================================
//  channel | dir | payload
//  req     | in  | raw_bytes[63:0], final_item
//  rsp     | out | sample_word[31:0], is_float, final_out
//  csr     | in  | source_format[3:0], always ready
//
//  One transaction per cycle sustained while rsp is ready; a request passes the
//  input register and then the result register around the converter to rsp.
//  Synchronous active-high reset clears valids and the format register (u8).
//  A stalled rsp holds the result; req keeps flowing until both stages fill.
module pcm_sample_format_converter (
   input logic             clock,
   input logic             reset,
   pcmfc_chan_if.sink      req,
   pcmfc_chan_if.source    rsp,
   pcmfc_chan_if.sink      csr
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [63:0]          s1_raw_ff, s1_raw_in;
   logic                 s1_final_ff, s1_final_in;
   logic                 s2_valid_ff, s2_valid_in;
   pcmfc_pkg::rsp_type   s2_rsp_ff, s2_rsp_in;
   pcmfc_pkg::fmt_type   fmt_ff, fmt_in;
   logic                 s1_take;
   logic                 s2_adv;
   logic [31:0]          conv_word;
   logic                 conv_float;

   // Stage handshake
   assign s2_adv    = s1_valid_ff && (!s2_valid_ff || rsp.ready);
   assign s1_take   = !s1_valid_ff || s2_adv;
   assign req.ready = s1_take;
   assign csr.ready = 1'b1;

   pcmfc_convert u_convert (
      .fmt      (fmt_ff),
      .raw      (s1_raw_ff),
      .word     (conv_word),
      .is_float (conv_float)
   );

   // Next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_raw_in   = s1_raw_ff;
      s1_final_in = s1_final_ff;
      if (s1_take) begin
         s1_valid_in = req.valid;
         s1_raw_in   = req.payload.raw_bytes;
         s1_final_in = req.payload.final_item;
      end
      s2_valid_in = s2_valid_ff;
      s2_rsp_in   = s2_rsp_ff;
      if (s2_adv) begin
         s2_valid_in           = 1'b1;
         s2_rsp_in.sample_word = conv_word;
         s2_rsp_in.is_float    = conv_float;
         s2_rsp_in.final_out   = s1_final_ff;
      end else if (rsp.ready) begin
         s2_valid_in = 1'b0;
      end
      fmt_in = fmt_ff;
      if (csr.valid) begin
         fmt_in = pcmfc_pkg::fmt_type'(csr.payload);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fmt_ff      <= pcmfc_pkg::FMT_U8;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         fmt_ff      <= fmt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_raw_ff   <= s1_raw_in;
      s1_final_ff <= s1_final_in;
      s2_rsp_ff   <= s2_rsp_in;
   end

   assign rsp.valid   = s2_valid_ff;
   assign rsp.payload = s2_rsp_ff;

`ifndef ASSERT_OFF
   // Nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

   // Integer results leave the upper half clear
   a_int_upper: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_rsp_ff.is_float) |-> (s2_rsp_ff.sample_word[31:16] == 16'd0))
      else $error("int16 result with upper bits set");

   // A held input stage keeps its sample
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_adv) |=> (s1_valid_ff && $stable(s1_raw_ff)))
      else $error("input stage lost a stalled sample");
`endif

endmodule
